@@ rtl/baa_pkg.sv @@
// Shared types, codes and sizes for the bump arena allocator.
`timescale 1ns / 1ps

package baa_pkg;

   localparam int unsigned ARENA_BYTES = 1048576;
   localparam int unsigned MAX_BLOCKS  = 64;

   localparam int unsigned OFS_W  = 20;
   localparam int unsigned SIZE_W = 21;
   localparam int unsigned SUM_W  = SIZE_W + 1;
   localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);

   // Reduction tree geometry: lanes are grouped in eights.
   localparam int unsigned GRP_W = 8;
   localparam int unsigned NGRP  = (MAX_BLOCKS + GRP_W - 1) / GRP_W;
   localparam int unsigned NLANE = NGRP * GRP_W;

   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_REALLOC = 2'd1;
   localparam logic [1:0] REQ_FREE    = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NOSPACE  = 2'd1;
   localparam logic [1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [OFS_W-1:0]  block_offset;
      logic [SIZE_W-1:0] request_size;
   } req_item_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [OFS_W-1:0] result_offset;
      logic [OFS_W-1:0] copy_source;
      logic [OFS_W-1:0] copy_length;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_REDUCE,
      ST_SELECT,
      ST_EXEC
   } state_type;

   // Command broadcast to every cell of the table.
   typedef struct packed {
      logic             remove;
      logic             append;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] append_idx;
      logic [OFS_W-1:0] key;
      logic [OFS_W-1:0] new_start;
      logic [OFS_W-1:0] new_end;
   } cell_cmd_type;

   // Result of the table search.
   typedef struct packed {
      logic             found;
      logic [OFS_W-1:0] fstart;
      logic [OFS_W-1:0] fend;
      logic [OFS_W-1:0] bump;
   } sel_type;

endpackage

@@ rtl/baa_cell.sv @@
// One table entry: holds a block's start and end, flags a key match and the newest entry.
`timescale 1ns / 1ps

module baa_cell import baa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] cell_idx,
   input  cell_cmd_type     cmd,
   input  logic             prefix_hit,
   input  logic [OFS_W-1:0] next_start,
   input  logic [OFS_W-1:0] next_end,
   output logic             match,
   output logic             last,
   output logic [OFS_W-1:0] start_ofs,
   output logic [OFS_W-1:0] end_ofs
);

   logic [OFS_W-1:0] start_ff, start_in;
   logic [OFS_W-1:0] end_ff, end_in;
   logic             match_ff, match_in;
   logic             last_ff, last_in;
   logic [CNT_W-1:0] idx_plus;
   logic             load;
   logic             shift;

   assign idx_plus = cell_idx + CNT_W'(1);
   assign match_in = (cell_idx < cmd.count) && (start_ff == cmd.key);
   assign last_in  = (idx_plus == cmd.count);
   assign load     = cmd.append && (cell_idx == cmd.append_idx);
   assign shift    = cmd.remove && prefix_hit;

   // Append wins over the close-up shift in the same cycle.
   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      if (load) begin
         start_in = cmd.new_start;
         end_in   = cmd.new_end;
      end else if (shift) begin
         start_in = next_start;
         end_in   = next_end;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         match_ff <= match_in;
         last_ff  <= last_in;
      end
   end

   assign match     = match_ff;
   assign last      = last_ff;
   assign start_ofs = start_ff;
   assign end_ofs   = end_ff;

endmodule

@@ rtl/baa_reduce.sv @@
// Two-stage registered tree: first match, its bounds, bump point and removal prefix.
`timescale 1ns / 1ps

module baa_reduce import baa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [MAX_BLOCKS-1:0] match,
   input  logic [MAX_BLOCKS-1:0] last,
   input  logic [OFS_W-1:0]      start_ofs [MAX_BLOCKS],
   input  logic [OFS_W-1:0]      end_ofs [MAX_BLOCKS],
   output sel_type               sel,
   output logic [MAX_BLOCKS-1:0] prefix
);

   logic [NLANE-1:0] match_pad;
   logic [NLANE-1:0] last_pad;
   logic [OFS_W-1:0] start_pad [NLANE];
   logic [OFS_W-1:0] end_pad [NLANE];

   logic [NLANE-1:0] pl_in, pl_ff;
   logic [NGRP-1:0]  any_in, any_ff;
   logic [OFS_W-1:0] gfs_in [NGRP];
   logic [OFS_W-1:0] gfs_ff [NGRP];
   logic [OFS_W-1:0] gfe_in [NGRP];
   logic [OFS_W-1:0] gfe_ff [NGRP];
   logic [OFS_W-1:0] gbump_in [NGRP];
   logic [OFS_W-1:0] gbump_ff [NGRP];

   logic [NGRP-1:0]       prior_hit;
   sel_type               sel_in, sel_ff;
   logic [MAX_BLOCKS-1:0] prefix_in, prefix_ff;

   // Pad the row out to whole groups with idle lanes.
   always_comb begin
      for (int l = 0; l < NLANE; l++) begin
         if (l < MAX_BLOCKS) begin
            match_pad[l] = match[l];
            last_pad[l]  = last[l];
            start_pad[l] = start_ofs[l];
            end_pad[l]   = end_ofs[l];
         end else begin
            match_pad[l] = 1'b0;
            last_pad[l]  = 1'b0;
            start_pad[l] = '0;
            end_pad[l]   = '0;
         end
      end
   end

   // Stage one: inside each group of eight.
   always_comb begin
      logic run;
      for (int g = 0; g < NGRP; g++) begin
         run         = 1'b0;
         gfs_in[g]   = '0;
         gfe_in[g]   = '0;
         gbump_in[g] = '0;
         for (int k = 0; k < GRP_W; k++) begin
            if (match_pad[g*GRP_W+k] && !run) begin
               gfs_in[g] = start_pad[g*GRP_W+k];
               gfe_in[g] = end_pad[g*GRP_W+k];
            end
            if (last_pad[g*GRP_W+k]) begin
               gbump_in[g] = gbump_in[g] | end_pad[g*GRP_W+k];
            end
            run              = run | match_pad[g*GRP_W+k];
            pl_in[g*GRP_W+k] = run;
         end
         any_in[g] = run;
      end
   end

   always_ff @(posedge clock) begin
      pl_ff    <= pl_in;
      gfs_ff   <= gfs_in;
      gfe_ff   <= gfe_in;
      gbump_ff <= gbump_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff <= '0;
      end else begin
         any_ff <= any_in;
      end
   end

   // Stage two: across the groups.
   always_comb begin
      logic seen;
      seen          = 1'b0;
      sel_in        = '0;
      for (int g = 0; g < NGRP; g++) begin
         prior_hit[g] = seen;
         if (any_ff[g] && !seen) begin
            sel_in.fstart = gfs_ff[g];
            sel_in.fend   = gfe_ff[g];
         end
         sel_in.bump = sel_in.bump | gbump_ff[g];
         seen        = seen | any_ff[g];
      end
      sel_in.found = seen;
      for (int l = 0; l < MAX_BLOCKS; l++) begin
         prefix_in[l] = pl_ff[l] | prior_hit[l / GRP_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff    <= '0;
         prefix_ff <= '0;
      end else begin
         sel_ff    <= sel_in;
         prefix_ff <= prefix_in;
      end
   end

   assign sel    = sel_ff;
   assign prefix = prefix_ff;

endmodule

@@ rtl/bump_arena_allocator_top.sv @@
// Top level of the bump arena allocator: control sequencer, cell row and result register.
`timescale 1ns / 1ps

// Bump arena allocator. Live blocks sit in a row of MAX_BLOCKS cells, oldest
// first, each cell holding one block's start and end offset. Allocate puts
// the new block at the end of the newest block (or at 0 when the table is
// empty); free and reallocate look up the oldest block with a matching start,
// remove it and close the gap by shifting every later cell one place down
// at once. Reallocate also reports a copy command (source, length);
// the data move is left to the user. An item goes from acceptance to a waiting
// result in order: the key is compared in every cell, the registered
// first-match tree reduces the cell row (groups of eight, then across
// groups), and the execute step decides and updates the table. No new item
// is taken until the previous one has left execute; the result register lets
// the next item in while the previous result waits, and the execute step
// holds only while that register is still occupied. The table contents need
// no clearing after reset; the live count alone decides which cells hold blocks.

module bump_arena_allocator_top import baa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   state_type state_ff, state_in;

   req_item_type req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   logic accept;
   logic exec_go;

   cell_cmd_type cmd;
   sel_type      sel;

   logic [MAX_BLOCKS-1:0] match;
   logic [MAX_BLOCKS-1:0] last;
   logic [MAX_BLOCKS-1:0] prefix;
   logic [OFS_W-1:0]      start_ofs [MAX_BLOCKS];
   logic [OFS_W-1:0]      end_ofs [MAX_BLOCKS];

   logic [SUM_W-1:0] sum;
   logic             nospace;
   logic [OFS_W-1:0] prev_len;
   logic             size_lt;

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MATCH;
         ST_MATCH:  state_in = ST_REDUCE;
         ST_REDUCE: state_in = ST_SELECT;
         ST_SELECT: state_in = ST_EXEC;
         ST_EXEC:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      exec_go   = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EXEC: exec_go   = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            exec_go   = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the item for the whole search.
   assign req_in = accept ? req_item : req_ff;

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   // ---------------------------------------------------------------
   // Execute: decide, build the result and the table command
   // ---------------------------------------------------------------
   // The bump point is the newest end; the tree gives 0 when the table is empty.
   assign sum      = SUM_W'(sel.bump) + SUM_W'(req_ff.request_size);
   assign nospace  = (sum >= SUM_W'(ARENA_BYTES));
   assign prev_len = sel.fend - sel.fstart;
   assign size_lt  = (req_ff.request_size < SIZE_W'(prev_len));

   always_comb begin
      rsp_in         = '0;
      count_in       = count_ff;
      cmd.remove     = 1'b0;
      cmd.append     = 1'b0;
      cmd.count      = count_ff;
      cmd.append_idx = count_ff;
      cmd.key        = req_ff.block_offset;
      cmd.new_start  = sel.bump;
      cmd.new_end    = sum[OFS_W-1:0];

      case (req_ff.req_type)
         REQ_ALLOC: begin
            if (nospace) begin
               rsp_in.status = STAT_NOSPACE;
            end else if (count_ff >= CNT_W'(MAX_BLOCKS)) begin
               rsp_in.status = STAT_FULL;
            end else begin
               rsp_in.status        = STAT_OK;
               rsp_in.result_offset = sel.bump;
               cmd.append           = 1'b1;
               count_in             = count_ff + CNT_W'(1);
            end
         end
         REQ_REALLOC: begin
            if (!sel.found) begin
               rsp_in.status = STAT_NOTFOUND;
            end else if (nospace) begin
               // Drop the old block even though the new one does not fit.
               rsp_in.status = STAT_NOSPACE;
               cmd.remove    = 1'b1;
               count_in      = count_ff - CNT_W'(1);
            end else begin
               rsp_in.status        = STAT_OK;
               rsp_in.result_offset = sel.bump;
               rsp_in.copy_source   = sel.fstart;
               rsp_in.copy_length   = size_lt ? req_ff.request_size[OFS_W-1:0]
                                              : prev_len;
               cmd.remove           = 1'b1;
               cmd.append           = 1'b1;
               cmd.append_idx       = count_ff - CNT_W'(1);
            end
         end
         REQ_FREE: begin
            if (!sel.found) begin
               rsp_in.status = STAT_NOTFOUND;
            end else begin
               rsp_in.status = STAT_OK;
               cmd.remove    = 1'b1;
               count_in      = count_ff - CNT_W'(1);
            end
         end
         default: rsp_in = '0;
      endcase

      // Touch the table only on the execute cycle that commits.
      if (!exec_go) begin
         cmd.remove = 1'b0;
         cmd.append = 1'b0;
         count_in   = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // ---------------------------------------------------------------
   // Cell row: each cell shifts down from its upper neighbour on removal
   // ---------------------------------------------------------------
   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      logic [OFS_W-1:0] nxt_start;
      logic [OFS_W-1:0] nxt_end;

      if (i < MAX_BLOCKS - 1) begin : g_mid
         assign nxt_start = start_ofs[i+1];
         assign nxt_end   = end_ofs[i+1];
      end else begin : g_top
         assign nxt_start = '0;
         assign nxt_end   = '0;
      end

      baa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (CNT_W'(i)),
         .cmd        (cmd),
         .prefix_hit (prefix[i]),
         .next_start (nxt_start),
         .next_end   (nxt_end),
         .match      (match[i]),
         .last       (last[i]),
         .start_ofs  (start_ofs[i]),
         .end_ofs    (end_ofs[i])
      );
   end

   baa_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .match     (match),
      .last      (last),
      .start_ofs (start_ofs),
      .end_ofs   (end_ofs),
      .sel       (sel),
      .prefix    (prefix)
   );

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("live count beyond table size");

   a_count_commit: assert property (@(posedge clock) disable iff (reset)
      !exec_go |=> $stable(count_ff))
      else $error("live count changed outside execute");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result raised without execute step");

   a_found_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> (sel.found == prefix[MAX_BLOCKS-1]))
      else $error("search result and removal prefix disagree");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the bump arena allocator: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top import baa_pkg::*; ();

   // Request code the block must ignore; it has no name in the package.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_ITEMS = 750;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 20;

   // One row of the directed table. Where typed is set, rs is the result read
   // straight off the behaviour; otherwise the arena predictor supplies it.
   typedef struct packed {
      logic         typed;
      req_item_type rq;
      rsp_item_type rs;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;

   // Arena predictor state: live blocks, oldest first.
   logic [OFS_W-1:0] live_start [MAX_BLOCKS];
   logic [OFS_W-1:0] live_end   [MAX_BLOCKS];
   int               live_count = 0;

   rsp_item_type pending_outcomes [$];
   stim_row_type directed_rows [$];

   int unsigned n_errors      = 0;
   int unsigned cycle_count   = 0;
   logic        quiet_stretch = 1'b0;
   logic        hold_pending  = 1'b0;

   bump_arena_allocator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Guard against a hung block: end the run as a failure past the limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      n_errors++;
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // ---------------------------------------------------------------------
   // Arena predictor
   // ---------------------------------------------------------------------

   // Next free offset: end of the newest block, or 0 with an empty table.
   function automatic logic [OFS_W-1:0] bump_offset();
      if (live_count == 0)
         return '0;
      return live_end[live_count-1];
   endfunction

   // Oldest block starting at the given offset, or -1.
   function automatic int find_block(input logic [OFS_W-1:0] start);
      for (int i = 0; i < live_count; i++)
         if (live_start[i] == start)
            return i;
      return -1;
   endfunction

   // Remove one block and close the gap so that the order holds.
   function automatic void drop_block(input int idx);
      for (int i = idx; i + 1 < live_count; i++) begin
         live_start[i] = live_start[i+1];
         live_end[i]   = live_end[i+1];
      end
      live_count--;
   endfunction

   function automatic void append_block(input logic [OFS_W-1:0] start,
                                        input logic [OFS_W-1:0] stop);
      live_start[live_count] = start;
      live_end[live_count]   = stop;
      live_count++;
   endfunction

   // Apply one request to the predicted arena and return its outcome.
   function automatic rsp_item_type arena_apply(input req_item_type rq);
      rsp_item_type     r;
      logic [OFS_W-1:0] base;
      logic [OFS_W-1:0] old_len;
      logic [SUM_W-1:0] top;
      int               idx;
      r    = '0;
      base = bump_offset();
      // Full-width sum, so oversized requests never wrap into range.
      top  = SUM_W'(base) + SUM_W'(rq.request_size);
      case (rq.req_type)
         REQ_ALLOC: begin
            if (top >= SUM_W'(ARENA_BYTES))
               r.status = STAT_NOSPACE;
            else if (live_count >= MAX_BLOCKS)
               r.status = STAT_FULL;
            else begin
               append_block(base, top[OFS_W-1:0]);
               r.result_offset = base;
            end
         end
         REQ_REALLOC: begin
            idx = find_block(rq.block_offset);
            if (idx < 0)
               r.status = STAT_NOTFOUND;
            else if (top >= SUM_W'(ARENA_BYTES)) begin
               // The old block goes even though the move fails.
               drop_block(idx);
               r.status = STAT_NOSPACE;
            end else begin
               old_len         = live_end[idx] - live_start[idx];
               r.copy_source   = live_start[idx];
               r.copy_length   = (rq.request_size < SIZE_W'(old_len)) ?
                                 rq.request_size[OFS_W-1:0] : old_len;
               r.result_offset = base;
               drop_block(idx);
               append_block(base, top[OFS_W-1:0]);
            end
         end
         REQ_FREE: begin
            idx = find_block(rq.block_offset);
            if (idx < 0)
               r.status = STAT_NOTFOUND;
            else
               drop_block(idx);
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic stim_row_type table_row(input logic typed, input logic [1:0] kind,
                                              input int unsigned ofs, input int unsigned size,
                                              input logic [1:0] st, input int unsigned res);
      stim_row_type row;
      row                  = '0;
      row.typed            = typed;
      row.rq.req_type      = kind;
      row.rq.block_offset  = OFS_W'(ofs);
      row.rq.request_size  = SIZE_W'(size);
      row.rs.status        = st;
      row.rs.result_offset = OFS_W'(res);
      return row;
   endfunction

   // Append one row to the directed table.
   function automatic void add_row(input stim_row_type row);
      directed_rows = {directed_rows, row};
   endfunction

   // Mostly modest sizes, some zero, some right on the arena boundary.
   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned roll;
      int unsigned room;
      roll = $urandom_range(99, 0);
      room = ARENA_BYTES - bump_offset();
      if (roll < 5)
         return '0;
      if (roll < 12)
         return SIZE_W'(room + $urandom_range(2, 0) - 1);
      return SIZE_W'($urandom_range(4096, 1));
   endfunction

   // Mostly the start of a live block; now and then an arbitrary offset.
   function automatic logic [OFS_W-1:0] pick_offset();
      if (live_count != 0 && $urandom_range(99, 0) < 85)
         return live_start[$urandom_range(live_count - 1, 0)];
      return OFS_W'($urandom);
   endfunction

   // Growing phases fill the table up to the full case; shrinking phases
   // empty it again so the bump point falls back to 0.
   function automatic req_item_type next_request(input logic growing);
      req_item_type rq;
      int unsigned  roll;
      roll = $urandom_range(99, 0);
      if (roll < 8) begin
         rq.req_type     = 2'($urandom);
         rq.block_offset = OFS_W'($urandom);
         rq.request_size = SIZE_W'($urandom);
         return rq;
      end
      if (growing)
         rq.req_type = (roll < 70) ? REQ_ALLOC : (roll < 85) ? REQ_REALLOC : REQ_FREE;
      else
         rq.req_type = (roll < 22) ? REQ_ALLOC : (roll < 38) ? REQ_REALLOC : REQ_FREE;
      rq.block_offset = pick_offset();
      rq.request_size = pick_size();
      return rq;
   endfunction

   // Offer one item, hold it until accepted, then record what must come back.
   task automatic offer(input stim_row_type row, output rsp_item_type want);
      rsp_item_type predicted;
      while (!quiet_stretch && $urandom_range(99, 0) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= row.rq;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted        = arena_apply(row.rq);
      want             = row.typed ? row.rs : predicted;
      pending_outcomes = {pending_outcomes, want};
   endtask

   // ---------------------------------------------------------------------
   // Result side: random back-pressure plus one long hold-off
   // ---------------------------------------------------------------------

   initial begin
      logic held;
      held      = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending && !held) begin
            // Hold off long enough for the block to fill and stall its input.
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= quiet_stretch || ($urandom_range(99, 0) >= 22);
      end
   end

   // Compare every accepted result with the oldest outstanding outcome.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0)
            report_error($sformatf("result item %h with nothing outstanding", rsp_item));
         else begin
            want = pending_outcomes.pop_front();
            if (rsp_item.status !== want.status)
               report_error($sformatf("status %0d, want %0d",
                                      rsp_item.status, want.status));
            if (rsp_item.result_offset !== want.result_offset)
               report_error($sformatf("result_offset %h, want %h",
                                      rsp_item.result_offset, want.result_offset));
            if (rsp_item.copy_source !== want.copy_source)
               report_error($sformatf("copy_source %h, want %h",
                                      rsp_item.copy_source, want.copy_source));
            if (rsp_item.copy_length !== want.copy_length)
               report_error($sformatf("copy_length %h, want %h",
                                      rsp_item.copy_length, want.copy_length));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      stim_row_type row;
      rsp_item_type got;
      int unsigned  n_random;
      int unsigned  mode_age;
      int unsigned  full_seen;
      logic         growing;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;

      // Directed rows. Empty table first: lookups miss, size extremes.
      add_row(table_row(1'b1, REQ_FREE,    0,       0,       STAT_NOTFOUND, 0));
      add_row(table_row(1'b1, REQ_REALLOC, 0,       5,       STAT_NOTFOUND, 0));
      add_row(table_row(1'b1, REQ_ALLOC,   0,       1048576, STAT_NOSPACE,  0));
      add_row(table_row(1'b1, REQ_ALLOC,   1048575, 2097151, STAT_NOSPACE,  0));
      // Largest block that fits, then a zero-size block at the very top.
      add_row(table_row(1'b1, REQ_ALLOC,   0,       1048575, STAT_OK,       0));
      add_row(table_row(1'b1, REQ_ALLOC,   0,       0,       STAT_OK, 1048575));
      add_row(table_row(1'b1, REQ_ALLOC,   0,       1,       STAT_NOSPACE,  0));
      // Failed move still frees the old block.
      add_row(table_row(1'b1, REQ_REALLOC, 1048575, 1,       STAT_NOSPACE,  0));
      add_row(table_row(1'b1, REQ_FREE,    0,       0,       STAT_OK,       0));
      add_row(table_row(1'b1, REQ_FREE,    0,       0,       STAT_NOTFOUND, 0));
      // Zero-size blocks sharing a start: the oldest one must be taken.
      add_row(table_row(1'b0, REQ_ALLOC,   0,       16,      STAT_OK, 0));
      add_row(table_row(1'b0, REQ_ALLOC,   0,       0,       STAT_OK, 0));
      add_row(table_row(1'b0, REQ_ALLOC,   0,       0,       STAT_OK, 0));
      add_row(table_row(1'b0, REQ_ALLOC,   0,       32,      STAT_OK, 0));
      add_row(table_row(1'b0, REQ_FREE,    16,      0,       STAT_OK, 0));
      // Moves shorter and longer than the old block.
      add_row(table_row(1'b0, REQ_REALLOC, 0,       8,       STAT_OK, 0));
      add_row(table_row(1'b0, REQ_REALLOC, 48,      100,     STAT_OK, 0));
      add_row(table_row(1'b1, REQ_REALLOC, 16,      1048576, STAT_NOSPACE,  0));
      // Unused code is ignored whatever the payload.
      add_row(table_row(1'b1, REQ_UNUSED,  'hABCDE, 2097151, STAT_OK,       0));
      add_row(table_row(1'b1, REQ_FREE,    12345,   0,       STAT_NOTFOUND, 0));
      add_row(table_row(1'b1, REQ_REALLOC, 1048575, 0,       STAT_NOTFOUND, 0));
      add_row(table_row(1'b0, REQ_REALLOC, 16,      3,       STAT_OK, 0));
      add_row(table_row(1'b0, REQ_ALLOC,   0,       2,       STAT_OK, 0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer(directed_rows[i], got);

      // Random traffic; ignored items do not advance the count.
      n_random  = 0;
      mode_age  = 0;
      full_seen = 0;
      growing   = 1'b1;
      while (n_random < RANDOM_ITEMS) begin
         quiet_stretch = (n_random >= 250 && n_random < 400);
         if (n_random == 520)
            hold_pending = 1'b1;
         row    = '0;
         row.rq = next_request(growing);
         offer(row, got);
         if (row.rq.req_type != REQ_UNUSED)
            n_random++;
         if (got.status == STAT_FULL)
            full_seen++;
         mode_age++;
         if (growing && (full_seen >= 4 || mode_age > 160)) begin
            growing  = 1'b0;
            mode_age = 0;
         end else if (!growing && (live_count == 0 || mode_age > 300)) begin
            growing   = 1'b1;
            mode_age  = 0;
            full_seen = 0;
         end
      end
      // Drop valid at the step of the last acceptance.
      req_valid     <= 1'b0;
      quiet_stretch  = 1'b0;

      // Drain outstanding results, then keep watching for strays.
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (n_errors == 0 && pending_outcomes.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
